// ----- rtl/core/mtvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mtvs_pkg;

	typedef struct packed {
		logic pir_raw;
		logic button_raw;
	} item_in_t;

	typedef struct packed {
		logic       valve_open_drive;
		logic       valve_close_drive;
		logic       green_led;
		logic       red_led;
		logic [1:0] phase;
	} item_out_t;

	typedef struct packed {
		logic [7:0] delay_seconds;
		logic [7:0] run_seconds;
		logic [9:0] pulse_ms;
		logic [9:0] abort_pulse_ms;
		logic [7:0] debounce_samples;
	} cfg_t;

	typedef struct packed {
		logic       stable;
		logic [7:0] count;
	} deb_t;

	localparam int unsigned PADDR_W = 5;

	localparam logic [2:0] REG_DELAY_SECONDS    = 3'd0;
	localparam logic [2:0] REG_RUN_SECONDS      = 3'd1;
	localparam logic [2:0] REG_PULSE_MS         = 3'd2;
	localparam logic [2:0] REG_ABORT_PULSE_MS   = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE_SAMPLES = 3'd4;

	localparam logic [7:0] DELAY_SECONDS_RST    = 8'd0;
	localparam logic [7:0] RUN_SECONDS_RST      = 8'd0;
	localparam logic [9:0] PULSE_MS_RST         = 10'd250;
	localparam logic [9:0] ABORT_PULSE_MS_RST   = 10'd150;
	localparam logic [7:0] DEBOUNCE_SAMPLES_RST = 8'd10;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_OPEN  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	localparam logic [1:0] PHASE_WAIT  = 2'd0;
	localparam logic [1:0] PHASE_DELAY = 2'd1;
	localparam logic [1:0] PHASE_RUN   = 2'd2;
	localparam logic [1:0] PHASE_DONE  = 2'd3;

	localparam logic [3:0] DIGIT_LAST = 4'd9;
	localparam logic [3:0] DIGIT_SAT  = 4'd15;

endpackage

`default_nettype wire

// ----- rtl/core/mtvs_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mtvs_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mtvs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output mtvs_pkg::cfg_t                     cfg
);

	mtvs_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[mtvs_pkg::PADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_seconds    <= mtvs_pkg::DELAY_SECONDS_RST;
			cfg_q.run_seconds      <= mtvs_pkg::RUN_SECONDS_RST;
			cfg_q.pulse_ms         <= mtvs_pkg::PULSE_MS_RST;
			cfg_q.abort_pulse_ms   <= mtvs_pkg::ABORT_PULSE_MS_RST;
			cfg_q.debounce_samples <= mtvs_pkg::DEBOUNCE_SAMPLES_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mtvs_pkg::REG_DELAY_SECONDS:    cfg_q.delay_seconds    <= pwdata[7:0];
				mtvs_pkg::REG_RUN_SECONDS:      cfg_q.run_seconds      <= pwdata[7:0];
				mtvs_pkg::REG_PULSE_MS:         cfg_q.pulse_ms         <= pwdata[9:0];
				mtvs_pkg::REG_ABORT_PULSE_MS:   cfg_q.abort_pulse_ms   <= pwdata[9:0];
				mtvs_pkg::REG_DEBOUNCE_SAMPLES: cfg_q.debounce_samples <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mtvs_pkg::REG_DELAY_SECONDS:    prdata = {24'd0, cfg_q.delay_seconds};
			mtvs_pkg::REG_RUN_SECONDS:      prdata = {24'd0, cfg_q.run_seconds};
			mtvs_pkg::REG_PULSE_MS:         prdata = {22'd0, cfg_q.pulse_ms};
			mtvs_pkg::REG_ABORT_PULSE_MS:   prdata = {22'd0, cfg_q.abort_pulse_ms};
			mtvs_pkg::REG_DEBOUNCE_SAMPLES: prdata = {24'd0, cfg_q.debounce_samples};
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/mtvs_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mtvs_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  mtvs_pkg::item_in_t       item,
	input  mtvs_pkg::cfg_t           cfg,
	output mtvs_pkg::item_out_t      res
);

	logic [3:0] ms_q, tens_q, hund_q, last_tens_q;
	logic       pir_stable_q, button_stable_q, green_q;
	logic [7:0] pir_count_q, button_count_q;
	logic [1:0] phase_q, pulse_kind_q;
	logic [7:0] delay_left_q, run_left_q;
	logic [9:0] pulse_left_q;

	logic [3:0] ms_n, tens_n, hund_n, last_tens_n;
	logic       pir_stable_n, button_stable_n, green_n;
	logic [7:0] pir_count_n, button_count_n;
	logic [1:0] phase_n, pulse_kind_n;
	logic [7:0] delay_left_n, run_left_n;
	logic [9:0] pulse_left_n;
	logic       strobe;
	mtvs_pkg::deb_t pir_deb, btn_deb;

	function automatic mtvs_pkg::deb_t settle(input logic raw, input logic stable,
			input logic [7:0] count, input logic [7:0] samples);
		mtvs_pkg::deb_t d;
		d.stable = stable;
		d.count  = 8'd0;
		if (stable != raw) begin
			d.count = count + 8'd1;
			if (d.count >= samples) begin
				d.count  = 8'd0;
				d.stable = raw;
			end
		end
		return d;
	endfunction

	function automatic logic [9:0] pulse_len(input logic [9:0] len);
		return (len == 10'd0) ? 10'd1 : len;
	endfunction

	always_comb begin
		ms_n            = ms_q;
		tens_n          = tens_q;
		hund_n          = hund_q;
		last_tens_n     = last_tens_q;
		pir_stable_n    = pir_stable_q;
		pir_count_n     = pir_count_q;
		button_stable_n = button_stable_q;
		button_count_n  = button_count_q;
		green_n         = green_q;
		phase_n         = phase_q;
		delay_left_n    = delay_left_q;
		run_left_n      = run_left_q;
		pulse_left_n    = pulse_left_q;
		pulse_kind_n    = pulse_kind_q;
		strobe          = 1'b0;
		pir_deb         = settle(item.pir_raw, pir_stable_q, pir_count_q, cfg.debounce_samples);
		btn_deb         = settle(item.button_raw, button_stable_q, button_count_q,
			cfg.debounce_samples);
		res             = '0;

		// tick counters
		if (ms_q >= mtvs_pkg::DIGIT_LAST) begin
			ms_n = 4'd0;
			if (tens_q >= mtvs_pkg::DIGIT_LAST) begin
				tens_n = 4'd0;
				if (hund_q < mtvs_pkg::DIGIT_SAT) begin
					hund_n = hund_q + 4'd1;
				end
			end else begin
				tens_n = tens_q + 4'd1;
			end
		end else begin
			ms_n = ms_q + 4'd1;
		end

		if (pulse_left_q == 10'd0) begin
			if (hund_n > mtvs_pkg::DIGIT_LAST) begin
				hund_n  = 4'd0;
				strobe  = 1'b1;
				green_n = ~green_q;
			end
			if (tens_n != last_tens_q) begin
				last_tens_n     = tens_n;
				button_stable_n = btn_deb.stable;
				button_count_n  = btn_deb.count;
				pir_stable_n    = pir_deb.stable;
				pir_count_n     = pir_deb.count;
			end
			if (!button_stable_n) begin
				phase_n      = mtvs_pkg::PHASE_WAIT;
				pulse_kind_n = mtvs_pkg::KIND_ABORT;
				pulse_left_n = pulse_len(cfg.abort_pulse_ms);
			end else begin
				case (phase_q)
					mtvs_pkg::PHASE_WAIT: begin
						if (pir_stable_n) begin
							phase_n      = mtvs_pkg::PHASE_DELAY;
							delay_left_n = cfg.delay_seconds;
							run_left_n   = cfg.run_seconds;
							hund_n       = 4'd0;
						end
					end
					mtvs_pkg::PHASE_DELAY: begin
						if (strobe) begin
							if (delay_left_q == 8'd0) begin
								pulse_kind_n = mtvs_pkg::KIND_OPEN;
								pulse_left_n = pulse_len(cfg.pulse_ms);
								phase_n      = mtvs_pkg::PHASE_RUN;
							end
							delay_left_n = delay_left_q - 8'd1;
						end
					end
					mtvs_pkg::PHASE_RUN: begin
						if (strobe) begin
							if (run_left_q == 8'd0) begin
								pulse_kind_n = mtvs_pkg::KIND_CLOSE;
								pulse_left_n = pulse_len(cfg.pulse_ms);
								phase_n      = mtvs_pkg::PHASE_DONE;
							end
							run_left_n = run_left_q - 8'd1;
						end
					end
					default: begin
						phase_n = mtvs_pkg::PHASE_WAIT;
					end
				endcase
			end
		end

		// drive outputs from the pulse in progress
		res.green_led = green_n;
		if (pulse_left_n != 10'd0) begin
			res.red_led = 1'b1;
			case (pulse_kind_n)
				mtvs_pkg::KIND_OPEN:  res.valve_open_drive = 1'b1;
				mtvs_pkg::KIND_CLOSE: res.valve_close_drive = 1'b1;
				mtvs_pkg::KIND_ABORT: begin
					res.valve_open_drive = 1'b1;
					res.green_led        = 1'b1;
				end
				default: ;
			endcase
			pulse_left_n = pulse_left_n - 10'd1;
			if (pulse_left_n == 10'd0) begin
				if (pulse_kind_n == mtvs_pkg::KIND_ABORT) begin
					green_n = 1'b0;
					if (pir_stable_n) begin
						phase_n      = mtvs_pkg::PHASE_DELAY;
						delay_left_n = cfg.delay_seconds;
						run_left_n   = cfg.run_seconds;
						hund_n       = 4'd0;
					end
				end
				pulse_kind_n = mtvs_pkg::KIND_NONE;
			end
		end
		res.phase = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q            <= 4'd0;
			tens_q          <= 4'd0;
			hund_q          <= 4'd0;
			last_tens_q     <= 4'd0;
			pir_stable_q    <= 1'b0;
			pir_count_q     <= 8'd0;
			button_stable_q <= 1'b1;
			button_count_q  <= 8'd0;
			green_q         <= 1'b0;
			phase_q         <= mtvs_pkg::PHASE_WAIT;
			delay_left_q    <= 8'd0;
			run_left_q      <= 8'd0;
			pulse_left_q    <= 10'd0;
			pulse_kind_q    <= mtvs_pkg::KIND_NONE;
		end else if (step) begin
			ms_q            <= ms_n;
			tens_q          <= tens_n;
			hund_q          <= hund_n;
			last_tens_q     <= last_tens_n;
			pir_stable_q    <= pir_stable_n;
			pir_count_q     <= pir_count_n;
			button_stable_q <= button_stable_n;
			button_count_q  <= button_count_n;
			green_q         <= green_n;
			phase_q         <= phase_n;
			delay_left_q    <= delay_left_n;
			run_left_q      <= run_left_n;
			pulse_left_q    <= pulse_left_n;
			pulse_kind_q    <= pulse_kind_n;
		end
	end

	a_kind_matches_left: assert property (@(posedge clk) disable iff (!arst_n)
		(pulse_left_q != 10'd0) == (pulse_kind_q != mtvs_pkg::KIND_NONE))
		else $error("pulse kind and pulse count disagree");

	a_digits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q <= mtvs_pkg::DIGIT_LAST && tens_q <= mtvs_pkg::DIGIT_LAST)
		else $error("tick counter out of range");

	a_debounce_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pulse_left_q != 10'd0) |=>
		$stable(pir_stable_q) && $stable(button_stable_q) && $stable(last_tens_q))
		else $error("debounce ran during a pulse");

	a_drive_leds: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (res.red_led == (res.valve_open_drive || res.valve_close_drive))
		&& !(res.valve_open_drive && res.valve_close_drive))
		else $error("valve drives and red led inconsistent");

endmodule

`default_nettype wire

// ----- rtl/core/motion_triggered_valve_sequencer.sv -----
// motion triggered valve sequencer
// one input item is one 1 ms tick carrying the raw motion and button levels;
// every accepted item gives exactly one result item with the valve drives,
// the two leds and the sequence phase for that tick
// input channel: in_valid / in_stall / in_data; an item is taken when
// in_valid is high and in_stall is low
// output channel: out_valid / out_stall / out_data, same rules
// the item lands in an input register and the state update runs between that
// register and the output register; one item per cycle is sustained while
// the receiver does not stall; when it stalls the result holds in the output
// register, an item already in the input register raises in_stall, and an
// empty input register still takes one more item, then in_stall rises
// configuration goes through the apb port (registers at 4*i, pready tied
// high); the user must only change it while no item is in flight (the
// block does not enforce this); reset (arst_n low) empties both registers,
// loads the register defaults, clears the counters and releases the button
`timescale 1ns / 1ps
`default_nettype none

module motion_triggered_valve_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  mtvs_pkg::item_in_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output mtvs_pkg::item_out_t                out_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mtvs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	mtvs_pkg::cfg_t      cfg;
	mtvs_pkg::item_in_t  item_s1;
	logic                valid_s1;
	mtvs_pkg::item_out_t res;
	mtvs_pkg::item_out_t out_q;
	logic                out_valid_q;
	logic                step;
	logic                take_in;

	assign step      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !step;
	assign take_in   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	mtvs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtvs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= in_data;
		end
		if (step) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
